FILE: rtl/core/mft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mft_pkg
// Shared types, codes and constants of the motor feedback tracker.
// ----------------------------------------------------------------------------
package mft_pkg;

   localparam int WINDOW_DEFAULT = 10;

   localparam int ANGLE_W   = 13;
   localparam int SPEED_W   = 16;
   localparam int CURRENT_W = 16;
   localparam int TEMP_W    = 8;
   localparam int IVAL_W    = 16;
   localparam int FILT_W    = 22;
   localparam int ROUNDS_W  = 24;
   localparam int TOTAL_W   = 38;
   localparam int RATE_W    = 17;
   localparam int SUM_W     = 20;
   localparam int CAL_W     = 6;
   localparam int ALIVE_W   = 10;
   localparam int CSR_DATA_W = 10;

   localparam logic [0:0] OP_FRAME = 1'b0;
   localparam logic [0:0] OP_TICK  = 1'b1;

   localparam logic [0:0] CSR_CAL_FRAMES     = 1'b0;
   localparam logic [0:0] CSR_ONLINE_TIMEOUT = 1'b1;

   localparam logic [CAL_W-1:0]   CAL_FRAMES_RESET = 6'd50;
   localparam logic [CAL_W-1:0]   FRAME_COUNT_MAX  = 6'd63;
   localparam logic [ALIVE_W-1:0] TIMEOUT_RESET    = 10'd100;

   localparam logic signed [ANGLE_W:0] HALF_TURN = 14'sd4096;

   // x/5 == (x * 52429) >> 18 for any 16-bit unsigned x
   localparam logic [15:0] RECIP_FIVE  = 16'd52429;
   localparam int          RECIP_SHIFT = 18;

   localparam logic [RATE_W-1:0] RATE_NUM = 17'd100000;

   typedef struct packed {
      logic capture;
      logic tick;
      logic calib;
      logic mult;
      logic update;
      logic div_start;
      logic rate_load;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic is_calib;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/core/mft_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mft channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface mft_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [0:0]                            operation;
   logic [mft_pkg::ANGLE_W-1:0]           angle_raw;
   logic signed [mft_pkg::SPEED_W-1:0]    speed_raw;
   logic signed [mft_pkg::CURRENT_W-1:0]  current_raw;
   logic [mft_pkg::TEMP_W-1:0]            temperature_raw;
   logic [mft_pkg::IVAL_W-1:0]            interval;

   modport source (output valid, operation, angle_raw, speed_raw, current_raw,
                   temperature_raw, interval, input ready);
   modport sink   (input valid, operation, angle_raw, speed_raw, current_raw,
                   temperature_raw, interval, output ready);
endinterface

interface mft_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [mft_pkg::ANGLE_W-1:0]          angle_now;
   logic signed [mft_pkg::SPEED_W-1:0]   speed_now;
   logic signed [mft_pkg::FILT_W-1:0]    current_filtered;
   logic [mft_pkg::TEMP_W-1:0]           temperature;
   logic signed [mft_pkg::ROUNDS_W-1:0]  round_count;
   logic signed [mft_pkg::TOTAL_W-1:0]   multiturn_angle;
   logic                                 online;
   logic [mft_pkg::RATE_W-1:0]           receive_rate;
   logic                                 calibrating;

   modport source (output valid, angle_now, speed_now, current_filtered, temperature,
                   round_count, multiturn_angle, online, receive_rate, calibrating,
                   input ready);
   modport sink   (input valid, angle_now, speed_now, current_filtered, temperature,
                   round_count, multiturn_angle, online, receive_rate, calibrating,
                   output ready);
endinterface

interface mft_csr_if;
   logic                              valid;
   logic                              ready;
   logic [0:0]                        reg_index;
   logic [mft_pkg::CSR_DATA_W-1:0]    wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mft_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mft_div
// Restoring divider: RATE_NUM / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mft_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [mft_pkg::SUM_W-1:0]     divisor,
   output logic                               done,
   output logic [mft_pkg::RATE_W-1:0]         quotient
);

   localparam int QW  = mft_pkg::RATE_W;
   localparam int DW  = mft_pkg::SUM_W;
   localparam int CW  = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[QW-1]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = mft_pkg::RATE_NUM;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: rtl/core/mft_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mft_dpath
// Tracker state, current filter, angle unwrap, interval ring and result register.
// ----------------------------------------------------------------------------
module mft_dpath #(
   parameter int WINDOW = mft_pkg::WINDOW_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire mft_pkg::cmd_type                       cmd,
   output mft_pkg::status_type                         status,
   input  wire logic                                   csr_write,
   input  wire logic [0:0]                             csr_index,
   input  wire logic [mft_pkg::CSR_DATA_W-1:0]         csr_data,
   input  wire logic [0:0]                             in_operation,
   input  wire logic [mft_pkg::ANGLE_W-1:0]            in_angle,
   input  wire logic signed [mft_pkg::SPEED_W-1:0]     in_speed,
   input  wire logic signed [mft_pkg::CURRENT_W-1:0]   in_current,
   input  wire logic [mft_pkg::TEMP_W-1:0]             in_temp,
   input  wire logic [mft_pkg::IVAL_W-1:0]             in_interval,
   output logic [mft_pkg::ANGLE_W-1:0]                 out_angle,
   output logic signed [mft_pkg::SPEED_W-1:0]          out_speed,
   output logic signed [mft_pkg::FILT_W-1:0]           out_current,
   output logic [mft_pkg::TEMP_W-1:0]                  out_temp,
   output logic signed [mft_pkg::ROUNDS_W-1:0]         out_rounds,
   output logic signed [mft_pkg::TOTAL_W-1:0]          out_total,
   output logic                                        out_online,
   output logic [mft_pkg::RATE_W-1:0]                  out_rate,
   output logic                                        out_calibrating
);

   localparam int POS_W = $clog2(WINDOW);
   localparam int AW    = mft_pkg::ANGLE_W;
   localparam int FW    = mft_pkg::FILT_W;
   localparam int RW    = mft_pkg::ROUNDS_W;
   localparam int TW    = mft_pkg::TOTAL_W;
   localparam int SW    = mft_pkg::SUM_W;
   localparam int IW    = mft_pkg::IVAL_W;
   localparam int QW    = 32 - mft_pkg::RECIP_SHIFT;

   // configuration
   logic [mft_pkg::CAL_W-1:0]   cal_frames_ff;
   logic [mft_pkg::ALIVE_W-1:0] timeout_ff;

   // latched item
   logic [0:0]                          op_ff;
   logic [AW-1:0]                       angle_in_ff;
   logic signed [mft_pkg::SPEED_W-1:0]  speed_in_ff;
   logic [15:0]                         cur_abs_ff;
   logic                                cur_neg_ff;
   logic [mft_pkg::TEMP_W-1:0]          temp_in_ff;
   logic [IW-1:0]                       ival_in_ff;
   logic [31:0]                         prod_ff;

   // tracker state
   logic [AW-1:0]                       angle_ff;
   logic [AW-1:0]                       offset_ff;
   logic [RW-1:0]                       rounds_ff;
   logic [mft_pkg::SPEED_W-1:0]         speed_ff;
   logic [FW-1:0]                       current_ff;
   logic [mft_pkg::TEMP_W-1:0]          temp_ff;
   logic [mft_pkg::CAL_W-1:0]           frame_count_ff;
   logic [mft_pkg::ALIVE_W-1:0]         alive_ff;
   logic                                alive_flag_ff;
   logic [IW-1:0]                       ring_ff [WINDOW];
   logic [POS_W-1:0]                    pos_ff;
   logic                                ring_full_ff;
   logic [SW-1:0]                       sum_ff;
   logic [mft_pkg::RATE_W-1:0]          rate_ff;

   // combinational
   logic [15:0]                         cur_abs_in;
   logic [QW-1:0]                       quot5;
   logic signed [QW-1:0]                step_c;
   logic [FW:0]                         filt_sum;
   logic signed [AW:0]                  angle_diff;
   logic [RW-1:0]                       rounds_in;
   logic [SW-1:0]                       sum_in;
   logic [mft_pkg::ALIVE_W-1:0]         alive_dec;
   logic [TW-1:0]                       total_in;
   logic                                calibrating;
   logic                                div_done;
   logic [mft_pkg::RATE_W-1:0]          div_quo;

   mft_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      cur_abs_in = in_current[15] ? 16'(-in_current) : 16'(in_current);
      quot5      = prod_ff[31:mft_pkg::RECIP_SHIFT];
      step_c     = cur_neg_ff ? $signed(quot5) : -$signed(quot5);
      filt_sum   = {current_ff[FW-1], current_ff}
                 + {step_c[QW-1], step_c, 8'b0};
      angle_diff = $signed({1'b0, angle_in_ff}) - $signed({1'b0, angle_ff});
      rounds_in  = rounds_ff;
      if (angle_diff > mft_pkg::HALF_TURN) begin
         rounds_in = rounds_ff - RW'(1);
      end else if (angle_diff < -mft_pkg::HALF_TURN) begin
         rounds_in = rounds_ff + RW'(1);
      end
      sum_in = (ring_full_ff ? sum_ff - SW'(ring_ff[pos_ff]) : sum_ff) + SW'(ival_in_ff);
      alive_dec = (alive_ff != '0) ? alive_ff - mft_pkg::ALIVE_W'(1) : '0;
      total_in  = {rounds_ff[RW-1], rounds_ff, {AW{1'b0}}}
                + TW'(angle_ff) - TW'(offset_ff);
      calibrating = (frame_count_ff <= cal_frames_ff);
   end

   assign status.is_tick  = (op_ff == mft_pkg::OP_TICK);
   assign status.is_calib = calibrating;
   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_frames_ff  <= mft_pkg::CAL_FRAMES_RESET;
         timeout_ff     <= mft_pkg::TIMEOUT_RESET;
         angle_ff       <= '0;
         offset_ff      <= '0;
         rounds_ff      <= '0;
         speed_ff       <= '0;
         current_ff     <= '0;
         temp_ff        <= '0;
         frame_count_ff <= '0;
         alive_ff       <= '0;
         alive_flag_ff  <= 1'b0;
         pos_ff         <= '0;
         ring_full_ff   <= 1'b0;
         sum_ff         <= '0;
         rate_ff        <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               mft_pkg::CSR_CAL_FRAMES:     cal_frames_ff <= csr_data[mft_pkg::CAL_W-1:0];
               mft_pkg::CSR_ONLINE_TIMEOUT: timeout_ff    <= csr_data;
               default: ;
            endcase
         end
         if (cmd.tick) begin
            alive_ff      <= alive_dec;
            alive_flag_ff <= (alive_dec != '0);
         end
         if (cmd.calib) begin
            angle_ff  <= angle_in_ff;
            offset_ff <= angle_in_ff;
            if (frame_count_ff < mft_pkg::FRAME_COUNT_MAX) begin
               frame_count_ff <= frame_count_ff + mft_pkg::CAL_W'(1);
            end
         end
         if (cmd.update) begin
            angle_ff   <= angle_in_ff;
            speed_ff   <= speed_in_ff;
            current_ff <= filt_sum[FW:1];
            temp_ff    <= temp_in_ff;
            rounds_ff  <= rounds_in;
            alive_ff   <= timeout_ff;
            sum_ff     <= sum_in;
            if (pos_ff == POS_W'(WINDOW - 1)) begin
               pos_ff       <= '0;
               ring_full_ff <= 1'b1;
            end else begin
               pos_ff <= pos_ff + POS_W'(1);
            end
         end
         if (cmd.rate_load) begin
            rate_ff <= (sum_ff == '0) ? '0 : div_quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= in_operation;
         angle_in_ff <= in_angle;
         speed_in_ff <= in_speed;
         cur_abs_ff  <= cur_abs_in;
         cur_neg_ff  <= in_current[15];
         temp_in_ff  <= in_temp;
         ival_in_ff  <= in_interval;
      end
      if (cmd.mult) begin
         prod_ff <= 32'(cur_abs_ff) * 32'(mft_pkg::RECIP_FIVE);
      end
      if (cmd.update) begin
         ring_ff[pos_ff] <= ival_in_ff;
      end
      if (cmd.load_out) begin
         out_angle       <= angle_ff;
         out_speed       <= speed_ff;
         out_current     <= current_ff;
         out_temp        <= temp_ff;
         out_rounds      <= rounds_ff;
         out_total       <= total_in;
         out_online      <= alive_flag_ff;
         out_rate        <= rate_ff;
         out_calibrating <= calibrating;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/mft_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mft_ctrl
// Sequencer: item capture, frame/tick dispatch, divide wait, result transfer.
// ----------------------------------------------------------------------------
module mft_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mft_pkg::cmd_type          cmd,
   input  wire mft_pkg::status_type  status
);

   typedef enum logic [2:0] {
      IDLE,
      DISPATCH,
      UPDATE,
      DIV_START,
      DIV_WAIT,
      RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_free     = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = DISPATCH;
            end
         end
         DISPATCH: begin
            if (status.is_tick) begin
               cmd.tick = 1'b1;
               state_in = RESULT;
            end else if (status.is_calib) begin
               cmd.calib = 1'b1;
               state_in  = RESULT;
            end else begin
               cmd.mult = 1'b1;
               state_in = UPDATE;
            end
         end
         UPDATE: begin
            cmd.update = 1'b1;
            state_in   = DIV_START;
         end
         DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = DIV_WAIT;
         end
         DIV_WAIT: begin
            if (status.div_done) begin
               cmd.rate_load = 1'b1;
               state_in      = RESULT;
            end
         end
         RESULT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/core/motor_feedback_tracker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// motor_feedback_tracker_unit
// Single-motor feedback tracker: offset capture, angle unwrap, current
// low-pass, online timeout and receive-rate averaging.
// ----------------------------------------------------------------------------
// One item is worked at a time and each gives one result. A tick or a
// calibration frame goes from capture through dispatch to the result load; a
// measured frame goes through capture, dispatch, update, divider start and
// divider wait to its result load, with the 17-step restoring divider
// that forms 100000 / interval_sum. A new item is taken while the previous
// result still waits in the output register; a result that is not taken stalls
// the next item at its last step. Register writes on the csr channel are taken
// every cycle and must only be issued while the block is idle.
module motor_feedback_tracker_unit #(
   parameter int WINDOW = mft_pkg::WINDOW_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mft_req_if.sink    req_bus,
   mft_rsp_if.source  rsp_bus,
   mft_csr_if.sink    csr_bus
);

   mft_pkg::cmd_type    cmd;
   mft_pkg::status_type status;
   logic                req_ready;
   logic                rsp_valid;

   mft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   mft_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write       (csr_bus.valid),
      .csr_index       (csr_bus.reg_index),
      .csr_data        (csr_bus.wdata),
      .in_operation    (req_bus.operation),
      .in_angle        (req_bus.angle_raw),
      .in_speed        (req_bus.speed_raw),
      .in_current      (req_bus.current_raw),
      .in_temp         (req_bus.temperature_raw),
      .in_interval     (req_bus.interval),
      .out_angle       (rsp_bus.angle_now),
      .out_speed       (rsp_bus.speed_now),
      .out_current     (rsp_bus.current_filtered),
      .out_temp        (rsp_bus.temperature),
      .out_rounds      (rsp_bus.round_count),
      .out_total       (rsp_bus.multiturn_angle),
      .out_online      (rsp_bus.online),
      .out_rate        (rsp_bus.receive_rate),
      .out_calibrating (rsp_bus.calibrating)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;
   assign csr_bus.ready = 1'b1;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_ready |=> !req_ready)
      else $error("item accepted while previous item in flight");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("result load did not raise response valid");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_out))
      else $error("response valid rose without a result load");

   a_no_restart_on_done: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> !cmd.div_start)
      else $error("divider restarted on completion");

endmodule
`default_nettype wire

FILE: sim/motor_feedback_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// motor_feedback_tracker_unit_tb
// Self-checking bench for the motor feedback tracker. A scoreboard class keeps
// its own copy of the tracker state, predicts the status after every accepted
// frame or tick and checks each response transfer in order. A short directed
// run covers angle wrap, current rounding, timeout expiry and rate from an
// empty ring, then random phases at several register settings follow, with
// random idles on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module motor_feedback_tracker_unit_tb;
   import mft_pkg::*;

   localparam int WINDOW   = WINDOW_DEFAULT;
   localparam int PHASES   = 6;
   localparam int PHASE_LEN = 290;

   typedef struct {
      logic [0:0]                  op;
      logic [ANGLE_W-1:0]          angle;
      logic signed [SPEED_W-1:0]   speed;
      logic signed [CURRENT_W-1:0] current;
      logic [TEMP_W-1:0]           temp;
      logic [IVAL_W-1:0]           interval;
   } feedback_type;

   typedef struct {
      logic [ANGLE_W-1:0]          angle_now;
      logic signed [SPEED_W-1:0]   speed_now;
      logic signed [FILT_W-1:0]    current_filtered;
      logic [TEMP_W-1:0]           temperature;
      logic signed [ROUNDS_W-1:0]  round_count;
      logic signed [TOTAL_W-1:0]   multiturn_angle;
      logic                        online;
      logic [RATE_W-1:0]           receive_rate;
      logic                        calibrating;
   } motor_status_type;

   class feedback_scoreboard;
      bit [CAL_W-1:0]          cal_frames;
      bit [ALIVE_W-1:0]        timeout;
      bit [ANGLE_W-1:0]        angle;
      bit [ANGLE_W-1:0]        offset;
      bit signed [ROUNDS_W-1:0] rounds;
      bit signed [SPEED_W-1:0] speed;
      int                      current;
      bit [TEMP_W-1:0]         temp;
      bit [CAL_W-1:0]          frame_cnt;
      bit [ALIVE_W-1:0]        alive_cnt;
      bit                      alive_flag;
      bit [IVAL_W-1:0]         ring [WINDOW];
      int                      pos;
      bit                      ring_full;
      bit [SUM_W-1:0]          sum;
      bit [RATE_W-1:0]         rate;
      motor_status_type        expected_status_q [$];
      int errors, n_checked, n_ticks, n_captures, n_measured, n_turns, n_offline;

      function new();
         cal_frames = CAL_FRAMES_RESET;
         timeout    = TIMEOUT_RESET;
      endfunction

      function int pending();
         return expected_status_q.size();
      endfunction

      function void set_reg(logic [0:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_CAL_FRAMES:     cal_frames = value[CAL_W-1:0];
            CSR_ONLINE_TIMEOUT: timeout = value[ALIVE_W-1:0];
            default: ;
         endcase
      endfunction

      // advance the tracker state by one accepted item and queue its status
      function void track_feedback(feedback_type it);
         motor_status_type s;
         int c, diff;
         longint acc;
         if (it.op == OP_TICK) begin
            n_ticks++;
            if (alive_cnt != 0) alive_cnt--;
            if (alive_flag && alive_cnt == 0) n_offline++;
            alive_flag = (alive_cnt != 0);
         end else if (frame_cnt <= cal_frames) begin
            n_captures++;
            angle  = it.angle;
            offset = it.angle;
            if (frame_cnt < FRAME_COUNT_MAX) frame_cnt++;
         end else begin
            n_measured++;
            diff    = int'(it.angle) - int'(angle);
            angle   = it.angle;
            speed   = it.speed;
            c       = int'(it.current) / -5;
            acc     = longint'(current) + longint'(c) * 256;
            current = int'(acc >>> 1);
            temp    = it.temp;
            if (diff > 4096) begin
               rounds = rounds - 1;
               n_turns++;
            end else if (diff < -4096) begin
               rounds = rounds + 1;
               n_turns++;
            end
            alive_cnt = timeout;
            if (ring_full) sum = sum - ring[pos];
            ring[pos] = it.interval;
            sum = sum + it.interval;
            pos++;
            if (pos >= WINDOW) begin
               pos = 0;
               ring_full = 1;
            end
            rate = (sum != 0) ? RATE_W'(100000 / sum) : '0;
         end
         s.angle_now        = angle;
         s.speed_now        = speed;
         s.current_filtered = current[FILT_W-1:0];
         s.temperature      = temp;
         s.round_count      = rounds;
         s.multiturn_angle  = TOTAL_W'(longint'(rounds) * 8192 + longint'(angle)
                                       - longint'(offset));
         s.online           = alive_flag;
         s.receive_rate     = rate;
         s.calibrating      = (frame_cnt <= cal_frames);
         expected_status_q.push_back(s);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] exp);
         if (got !== exp)
            report($sformatf("status %0d %s: got %0h, expected %0h",
                             n_checked, name, got, exp));
      endtask

      task check_status(motor_status_type got);
         motor_status_type exp;
         if (expected_status_q.size() == 0) begin
            report("status transfer with nothing pending");
            return;
         end
         exp = expected_status_q.pop_front();
         compare_field("angle_now", got.angle_now, exp.angle_now);
         compare_field("speed_now", got.speed_now, exp.speed_now);
         compare_field("current_filtered", got.current_filtered, exp.current_filtered);
         compare_field("temperature", got.temperature, exp.temperature);
         compare_field("round_count", got.round_count, exp.round_count);
         compare_field("multiturn_angle", got.multiturn_angle, exp.multiturn_angle);
         compare_field("online", got.online, exp.online);
         compare_field("receive_rate", got.receive_rate, exp.receive_rate);
         compare_field("calibrating", got.calibrating, exp.calibrating);
         n_checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   logic rsp_hold;
   bit   steady;
   int   items_sent;
   int   prev_angle;
   feedback_scoreboard sb;

   mft_req_if req_if ();
   mft_rsp_if rsp_if ();
   mft_csr_if csr_if ();

   motor_feedback_tracker_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always #1 clock = ~clock;

   function int pick_gap();
      if (steady || $urandom_range(99) >= 37) return 0;
      return $urandom_range(1, 28);
   endfunction

   function feedback_type random_item();
      feedback_type it;
      int pick, a;
      it.op       = ($urandom_range(99) < 25) ? OP_TICK : OP_FRAME;
      it.speed    = SPEED_W'($urandom);
      it.current  = CURRENT_W'($urandom);
      it.temp     = TEMP_W'($urandom);
      pick = $urandom_range(9);
      if (pick == 0) it.interval = IVAL_W'($urandom);
      else if (pick == 1) it.interval = '0;
      else it.interval = IVAL_W'($urandom_range(1, 200));
      pick = $urandom_range(19);
      case (pick)
         0: a = $urandom;
         1: a = prev_angle + (($urandom_range(1)) ? 4096 : -4096);
         2: a = prev_angle + (($urandom_range(1)) ? 4097 : -4097);
         default: a = prev_angle + $urandom_range(2000) - 1000;
      endcase
      it.angle = ANGLE_W'(a);
      return it;
   endfunction

   task send_item(feedback_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.operation       <= it.op;
      req_if.angle_raw       <= it.angle;
      req_if.speed_raw       <= it.speed;
      req_if.current_raw     <= it.current;
      req_if.temperature_raw <= it.temp;
      req_if.interval        <= it.interval;
      do @(posedge clock); while (!req_if.ready);
      sb.track_feedback(it);
      if (it.op == OP_FRAME) prev_angle = it.angle;
      items_sent++;
   endtask

   task send_frame(int a, int s, int c, int t, int iv);
      feedback_type it;
      it.op = OP_FRAME;
      it.angle = ANGLE_W'(a);
      it.speed = SPEED_W'(s);
      it.current = CURRENT_W'(c);
      it.temp = TEMP_W'(t);
      it.interval = IVAL_W'(iv);
      send_item(it);
   endtask

   task send_tick();
      feedback_type it;
      it = random_item();
      it.op = OP_TICK;
      send_item(it);
   endtask

   task write_reg(logic [0:0] idx, int value);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wdata     <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_if.ready);
      sb.set_reg(idx, value[CSR_DATA_W-1:0]);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every pending status has come back
   task drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // response side: random backpressure plus one long hold-off
   initial begin
      motor_status_type got;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.angle_now        = rsp_if.angle_now;
            got.speed_now        = rsp_if.speed_now;
            got.current_filtered = rsp_if.current_filtered;
            got.temperature      = rsp_if.temperature;
            got.round_count      = rsp_if.round_count;
            got.multiturn_angle  = rsp_if.multiturn_angle;
            got.online           = rsp_if.online;
            got.receive_rate     = rsp_if.receive_rate;
            got.calibrating      = rsp_if.calibrating;
            sb.check_status(got);
         end
         rsp_if.ready <= !rsp_hold && (steady || $urandom_range(99) >= 37);
      end
   end

   initial begin
      rsp_hold = 1'b0;
      wait (items_sent >= 1200);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #2000000;
      $display("** motor_feedback_tracker_unit: FAILED **");
      $finish;
   end

   initial begin
      int cal_list [PHASES];
      int tmo_list [PHASES];
      cal_list = '{2, 63, 0, 17, 1, 40};
      tmo_list = '{20, 1023, 1, 5, 300, 2};
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      steady = 1'b0;
      items_sent = 0;
      prev_angle = 0;
      req_if.valid = 1'b0;
      req_if.operation = OP_FRAME;
      req_if.angle_raw = '0;
      req_if.speed_raw = '0;
      req_if.current_raw = '0;
      req_if.temperature_raw = '0;
      req_if.interval = '0;
      csr_if.valid = 1'b0;
      csr_if.reg_index = CSR_CAL_FRAMES;
      csr_if.wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: one capture frame, then wrap, rounding, ring and timeout cases
      write_reg(CSR_CAL_FRAMES, 0);
      write_reg(CSR_ONLINE_TIMEOUT, 3);
      send_tick();
      send_frame(8191, 100, 50, 20, 7);
      send_frame(0, -32768, -32768, 255, 0);
      send_frame(8191, 32767, 32767, 0, 65535);
      send_frame(4095, -1, 0, 1, 1);
      send_frame(0, 1, -1, 2, 2);
      send_frame(4096, 0, -4, 3, 3);
      send_frame(0, 2, -5, 4, 4);
      send_frame(4097, 3, -6, 5, 5);
      send_frame(0, 4, 4, 6, 6);
      send_frame(1, 5, 5, 7, 7);
      send_frame(2, 6, 1, 8, 8);
      send_frame(3, 7, 6, 9, 9);
      repeat (4) send_tick();
      req_if.valid <= 1'b0;
      drain();
      write_reg(CSR_ONLINE_TIMEOUT, 0);
      send_frame(5, 8, 9, 10, 10);
      send_tick();
      req_if.valid <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_reg(CSR_CAL_FRAMES, cal_list[p]);
         write_reg(CSR_ONLINE_TIMEOUT, tmo_list[p]);
         steady = (p == 2);
         repeat (PHASE_LEN) send_item(random_item());
         req_if.valid <= 1'b0;
      end
      steady = 1'b0;
      drain();

      $display("Covered %0d items: %0d ticks, %0d offset captures, %0d measured frames.",
               items_sent, sb.n_ticks, sb.n_captures, sb.n_measured);
      $display("Saw %0d turn-count steps and %0d online-to-offline drops; %0d statuses checked.",
               sb.n_turns, sb.n_offline, sb.n_checked);
      if (sb.errors == 0) begin
         $display("** motor_feedback_tracker_unit: PASSED **");
      end else begin
         $display("** motor_feedback_tracker_unit: FAILED **");
      end
      $finish;
   end

endmodule
